FILE: hw/rtl/ttl_pkg.sv
// Shared types, constants and helpers for the text token lexer.
`timescale 1ns / 1ps

package ttl_pkg;

  // Line counter width and its derived limits
  localparam int LINE_BITS = 16;
  localparam int LINE_CMP_W = LINE_BITS + 16;
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [15:0] OUT_LINE_MAX = 16'hFFFF;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Token kinds
  localparam logic [1:0] KIND_SPECIAL = 2'd0;
  localparam logic [1:0] KIND_STRING  = 2'd1;
  localparam logic [1:0] KIND_WORD    = 2'd2;
  localparam logic [1:0] KIND_NUMBER  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_TOKEN       = 2'd0;
  localparam logic [1:0] ST_END         = 2'd1;
  localparam logic [1:0] ST_UNKNOWN     = 2'd2;
  localparam logic [1:0] ST_OPEN_STRING = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_STRING,
    MODE_STOPPED,
    MODE_ERROR
  } lex_mode_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  token_kind;
    logic        first_of_token;
    logic        last_of_token;
    logic [15:0] line_number;
    logic [1:0]  status;
  } ttl_result_t;

  // Up to two words handed from front to queue per byte
  typedef struct packed {
    logic        valid0;
    logic        valid1;
    ttl_result_t word0;
    ttl_result_t word1;
  } ttl_push_t;

  // Clamp a line count to the 16-bit output field
  function automatic logic [15:0] line_out(input logic [LINE_BITS-1:0] v);
    logic [LINE_CMP_W-1:0] w;
    w = LINE_CMP_W'(v);
    if (w > LINE_CMP_W'(OUT_LINE_MAX)) begin
      return OUT_LINE_MAX;
    end
    return w[15:0];
  endfunction

  function automatic ttl_result_t make_word(input logic [7:0] b, input logic [1:0] kind,
                                            input logic first, input logic last,
                                            input logic [15:0] line, input logic [1:0] st);
    ttl_result_t r;
    r.out_byte       = b;
    r.token_kind     = kind;
    r.first_of_token = first;
    r.last_of_token  = last;
    r.line_number    = line;
    r.status         = st;
    return r;
  endfunction

endpackage

FILE: hw/rtl/ttl_if.sv
// Valid/ready channel interfaces for lexer input bytes and result words.
`timescale 1ns / 1ps

interface ttl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source(output valid, in_byte, end_of_buffer, input ready);
  modport sink(input valid, in_byte, end_of_buffer, output ready);
endinterface

interface ttl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  token_kind;
  logic        first_of_token;
  logic        last_of_token;
  logic [15:0] line_number;
  logic [1:0]  status;

  modport source(output valid, out_byte, token_kind, first_of_token, last_of_token,
                 line_number, status, input ready);
  modport sink(input valid, out_byte, token_kind, first_of_token, last_of_token,
               line_number, status, output ready);
endinterface

FILE: hw/rtl/ttl_front.sv
// Front end: classifies each input byte, tracks lexer state, builds result words.
`timescale 1ns / 1ps

module ttl_front import ttl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ttl_in_if.sink    in_ch,
  input  logic      room,
  output ttl_push_t push
);

  function automatic logic is_special(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h3D, 8'h3B, 8'h2C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  logic [7:0] c;
  logic       eob;
  logic       accept;

  lex_mode_t            mode, mode_next;
  logic [7:0]           held_byte, held_byte_next;
  logic                 held_valid, held_valid_next;
  logic [1:0]           held_kind, held_kind_next;
  logic                 held_first, held_first_next;
  logic [LINE_BITS-1:0] token_line, token_line_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;

  logic c_special, c_quote, c_letter, c_digit, c_space, c_num_start, c_in_num, c_nul;
  logic cont, do_start, unknown, emit_held, emit_last;

  ttl_result_t slot [2];
  logic [1:0]  slot_cnt;

  assign c           = in_ch.in_byte;
  assign eob         = in_ch.end_of_buffer;
  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  // Classify the byte against the current mode
  always_comb begin
    c_special   = is_special(c);
    c_quote     = (c == CH_QUOTE);
    c_letter    = is_letter(c);
    c_digit     = is_digit(c);
    c_space     = is_space(c);
    c_num_start = c_digit || (c == CH_DOT) || (c == CH_MINUS);
    c_in_num    = c_digit || (c == CH_DOT) || (c == CH_E) || (c == CH_MINUS) || (c == CH_PLUS);
    c_nul       = (c == CH_NUL);
    cont        = (mode == MODE_WORD) ? (c_letter || c_digit) : c_in_num;
    do_start    = 1'b0;
    emit_held   = 1'b0;
    emit_last   = 1'b1;
    unique case (mode)
      MODE_WORD, MODE_NUMBER: begin
        do_start  = !cont;
        emit_held = held_valid;
        emit_last = !cont;
      end
      MODE_STRING: begin
        emit_held = held_valid;
        emit_last = 1'b0;
      end
      MODE_IDLE: begin
        do_start  = 1'b1;
        emit_held = held_valid;
      end
      MODE_STOPPED, MODE_ERROR: begin
      end
      default: do_start = 1'b1;
    endcase
    unknown = do_start &&
              !(c_special || c_quote || c_letter || c_space || c_num_start || c_nul);
  end

  // Next state for one byte, before the end mark clears everything
  always_comb begin
    mode_next       = mode;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    held_kind_next  = held_kind;
    held_first_next = held_first;
    token_line_next = token_line;
    line_count_next = line_count;
    unique case (mode)
      MODE_WORD, MODE_NUMBER: begin
        if (cont) begin
          held_byte_next  = c;
          held_kind_next  = (mode == MODE_WORD) ? KIND_WORD : KIND_NUMBER;
          held_first_next = 1'b0;
          held_valid_next = 1'b1;
        end else begin
          held_valid_next = 1'b0;
          mode_next       = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        held_byte_next  = c;
        held_kind_next  = KIND_STRING;
        held_first_next = 1'b0;
        held_valid_next = 1'b1;
        if (c_quote) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_IDLE: held_valid_next = 1'b0;
      MODE_STOPPED, MODE_ERROR: begin
      end
      default: begin
        mode_next       = MODE_IDLE;
        held_valid_next = 1'b0;
      end
    endcase
    // Start a new token, count a line, stop or flag an error
    if (do_start) begin
      if (c_special || c_quote || c_letter || (!c_space && c_num_start)) begin
        held_byte_next  = c;
        held_first_next = 1'b1;
        held_valid_next = 1'b1;
        token_line_next = line_count;
      end
      if (c_special) begin
        held_kind_next = KIND_SPECIAL;
      end else if (c_quote) begin
        held_kind_next = KIND_STRING;
        mode_next      = MODE_STRING;
      end else if (c_letter) begin
        held_kind_next = KIND_WORD;
        mode_next      = MODE_WORD;
      end else if (c_space) begin
        if (c == CH_LF && line_count < LINE_MAX) begin
          line_count_next = line_count + LINE_ONE;
        end
      end else if (c_num_start) begin
        held_kind_next = KIND_NUMBER;
        mode_next      = MODE_NUMBER;
      end else if (c_nul) begin
        mode_next = MODE_STOPPED;
      end else begin
        mode_next = MODE_ERROR;
      end
    end
  end

  // Build the result words in order: held byte, error, end of buffer
  always_comb begin
    slot[0]  = '0;
    slot[1]  = '0;
    slot_cnt = 2'd0;
    if (emit_held) begin
      slot[slot_cnt[0]] = make_word(held_byte, held_kind, held_first, emit_last,
                                    line_out(token_line), ST_TOKEN);
      slot_cnt = slot_cnt + 2'd1;
    end
    if (unknown && slot_cnt < 2'd2) begin
      slot[slot_cnt[0]] = make_word(8'h00, KIND_SPECIAL, 1'b0, 1'b0,
                                    line_out(line_count), ST_UNKNOWN);
      slot_cnt = slot_cnt + 2'd1;
    end
    if (eob && slot_cnt < 2'd2) begin
      if (mode_next == MODE_STRING) begin
        slot[slot_cnt[0]] = make_word(8'h00, KIND_SPECIAL, 1'b0, 1'b0,
                                      line_out(line_count_next), ST_OPEN_STRING);
        slot_cnt = slot_cnt + 2'd1;
      end else if (!unknown) begin
        if (held_valid_next) begin
          slot[slot_cnt[0]] = make_word(held_byte_next, held_kind_next, held_first_next,
                                        1'b1, line_out(token_line_next), ST_END);
        end else begin
          slot[slot_cnt[0]] = make_word(8'h00, KIND_SPECIAL, 1'b0, 1'b0,
                                        line_out(line_count_next), ST_END);
        end
        slot_cnt = slot_cnt + 2'd1;
      end
    end
  end

  assign push.valid0 = accept && (slot_cnt != 2'd0);
  assign push.valid1 = accept && (slot_cnt == 2'd2);
  assign push.word0  = slot[0];
  assign push.word1  = slot[1];

  // Advance state on each accepted byte; the end mark resets the lexer
  always_ff @(posedge clk) begin
    if (rst || (accept && eob)) begin
      mode       <= MODE_IDLE;
      held_byte  <= '0;
      held_valid <= 1'b0;
      held_kind  <= '0;
      held_first <= 1'b0;
      token_line <= LINE_ONE;
      line_count <= LINE_ONE;
    end else if (accept) begin
      mode       <= mode_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      held_kind  <= held_kind_next;
      held_first <= held_first_next;
      token_line <= token_line_next;
      line_count <= line_count_next;
    end
  end

  a_no_held_when_halted: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (mode != MODE_STOPPED && mode != MODE_ERROR))
    else $error("held byte present while lexer is halted");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && eob) |=> (mode == MODE_IDLE && !held_valid && line_count == LINE_ONE))
    else $error("end of buffer did not reset lexer state");

endmodule

FILE: hw/rtl/ttl_queue.sv
// Short result queue: takes up to two words per cycle, releases one.
`timescale 1ns / 1ps

module ttl_queue import ttl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ttl_push_t   push,
  output logic        room,
  output logic        q_valid,
  output ttl_result_t q_word,
  input  logic        pop
);

  ttl_result_t     entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign room    = count <= Q_CW'(Q_DEPTH - 2);
  assign q_valid = count != '0;
  assign q_word  = entries[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push.valid0) begin
      entries[wr_ptr] <= push.word0;
    end
    if (push.valid1) begin
      entries[wr_ptr + Q_AW'(1)] <= push.word1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push.valid0) + Q_AW'(push.valid1);
      rd_ptr <= rd_ptr + Q_AW'(pop);
      count  <= count + Q_CW'(push.valid0) + Q_CW'(push.valid1) - Q_CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("queue occupancy out of range");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.valid0 |-> room)
    else $error("word pushed without two free slots");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.valid1 |-> push.valid0)
    else $error("second word pushed without first");

endmodule

FILE: hw/rtl/ttl_back.sv
// Back end: moves queued words into the output register toward the consumer.
`timescale 1ns / 1ps

module ttl_back import ttl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  ttl_result_t q_word,
  output logic        pop,
  ttl_out_if.source   out_ch
);

  logic        out_valid;
  ttl_result_t out_word;

  // Take a word whenever the output register is free or being drained
  assign pop = q_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= q_word;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.out_byte       = out_word.out_byte;
  assign out_ch.token_kind     = out_word.token_kind;
  assign out_ch.first_of_token = out_word.first_of_token;
  assign out_ch.last_of_token  = out_word.last_of_token;
  assign out_ch.line_number    = out_word.line_number;
  assign out_ch.status         = out_word.status;

endmodule

FILE: hw/rtl/text_token_lexer.sv
// Top level of the streaming text token lexer.
`timescale 1ns / 1ps

// Text token lexer: takes one text byte per input word and emits one output word per
// token byte (with kind, first/last marks and start line) plus status words for end of
// buffer, unknown characters and unterminated strings. Each token byte appears one input
// byte later, since its last mark is only known when the next byte arrives. The front
// end accepts a byte every clock while the queue has room; each byte yields zero, one
// or two words, written into a four-word queue, and the output register delivers one
// word per clock while out_ch is ready. Input is stalled only while the queue holds
// fewer than two free slots, so sustained throughput is one byte per clock while the
// consumer keeps up and no byte yields two words; words pass the queue, then the output
// register. A byte with the end mark resets the line counter and all lexer state.
module text_token_lexer import ttl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ttl_in_if.sink    in_ch,
  ttl_out_if.source out_ch
);

  ttl_push_t   push;
  logic        room;
  logic        q_valid;
  ttl_result_t q_word;
  logic        pop;

  ttl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  ttl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .q_valid (q_valid),
    .q_word  (q_word),
    .pop     (pop)
  );

  ttl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_word  (q_word),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: bench/ttl_stream_checker.sv
// Checker for the text token lexer: predicts result words from accepted bytes and compares.
`timescale 1ns / 1ps

module ttl_stream_checker import ttl_pkg::*; (
  input  logic clk,
  input  logic rst,
  ttl_in_if    in_ch,
  ttl_out_if   out_ch,
  output int   fail_count,
  output int   words_pending
);

  // Predicted lexer state
  lex_mode_t            mode;
  logic [7:0]           held_char;
  logic                 held_live;
  logic [1:0]           held_kind_q;
  logic                 held_starts;
  logic [LINE_BITS-1:0] token_start_line;
  logic [LINE_BITS-1:0] line_now;

  // Words predicted but not yet seen on the output
  ttl_result_t words_due[$];

  function automatic logic is_special_char(input logic [7:0] c);
    return c inside {"(", ")", "{", "}", "[", "]", "<", ">", "=", ";", ","};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_LF, CH_SPACE, CH_TAB, CH_CR};
  endfunction

  function automatic logic starts_num(input logic [7:0] c);
    return is_digit(c) || c == CH_DOT || c == CH_MINUS;
  endfunction

  function automatic logic continues_num(input logic [7:0] c);
    return is_digit(c) || c == CH_DOT || c == CH_E || c == CH_MINUS || c == CH_PLUS;
  endfunction

  // Clamp the line counter to the 16-bit line field
  function automatic logic [15:0] clamp_line(input logic [LINE_BITS-1:0] v);
    if (LINE_BITS > 16 && longint'(v) > longint'(OUT_LINE_MAX)) begin
      return OUT_LINE_MAX;
    end
    return 16'(v);
  endfunction

  task automatic queue_word(input logic [7:0] b, input logic [1:0] kind, input logic first,
                            input logic last, input logic [15:0] line, input logic [1:0] st);
    words_due.insert(words_due.size(),
                     ttl_result_t'{out_byte: b, token_kind: kind, first_of_token: first,
                                   last_of_token: last, line_number: line, status: st});
  endtask

  // Release the held token byte, if any
  task automatic flush_held(input logic last);
    if (held_live) begin
      queue_word(held_char, held_kind_q, held_starts, last, clamp_line(token_start_line),
                 ST_TOKEN);
      held_live = 1'b0;
    end
  endtask

  task automatic take_char(input logic [7:0] c, input logic [1:0] kind, input logic starts);
    if (starts) begin
      token_start_line = line_now;
    end
    held_char   = c;
    held_kind_q = kind;
    held_starts = starts;
    held_live   = 1'b1;
  endtask

  task automatic clear_lexer();
    mode             = MODE_IDLE;
    held_char        = '0;
    held_live        = 1'b0;
    held_kind_q      = KIND_SPECIAL;
    held_starts      = 1'b0;
    token_start_line = LINE_ONE;
    line_now         = LINE_ONE;
  endtask

  // Handle a byte with no token open; flag an unknown byte
  task automatic open_token(input logic [7:0] c, output logic failed);
    failed = 1'b0;
    if (is_special_char(c)) begin
      take_char(c, KIND_SPECIAL, 1'b1);
    end else if (c == CH_QUOTE) begin
      take_char(c, KIND_STRING, 1'b1);
      mode = MODE_STRING;
    end else if (is_letter(c)) begin
      take_char(c, KIND_WORD, 1'b1);
      mode = MODE_WORD;
    end else if (is_blank(c)) begin
      if (c == CH_LF && line_now != LINE_MAX) begin
        line_now = line_now + LINE_ONE;
      end
    end else if (starts_num(c)) begin
      take_char(c, KIND_NUMBER, 1'b1);
      mode = MODE_NUMBER;
    end else if (c == CH_NUL) begin
      mode = MODE_STOPPED;
    end else begin
      queue_word(8'd0, KIND_SPECIAL, 1'b0, 1'b0, clamp_line(line_now), ST_UNKNOWN);
      mode   = MODE_ERROR;
      failed = 1'b1;
    end
  endtask

  // Advance the lexer by one accepted byte
  task automatic lex_byte(input logic [7:0] c, input logic eob);
    logic failed;
    logic stays;
    failed = 1'b0;
    case (mode)
      MODE_WORD, MODE_NUMBER: begin
        stays = (mode == MODE_WORD) ? (is_letter(c) || is_digit(c)) : continues_num(c);
        if (stays) begin
          flush_held(1'b0);
          take_char(c, (mode == MODE_WORD) ? KIND_WORD : KIND_NUMBER, 1'b0);
        end else begin
          flush_held(1'b1);
          mode = MODE_IDLE;
          open_token(c, failed);
        end
      end
      MODE_STRING: begin
        flush_held(1'b0);
        take_char(c, KIND_STRING, 1'b0);
        if (c == CH_QUOTE) begin
          mode = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        flush_held(1'b1);
        open_token(c, failed);
      end
      default: ;  // stopped or in error: drop the byte
    endcase

    // End mark: close out the buffer and start over
    if (eob) begin
      if (mode == MODE_STRING) begin
        queue_word(8'd0, KIND_SPECIAL, 1'b0, 1'b0, clamp_line(line_now), ST_OPEN_STRING);
      end else if (!failed) begin
        if (held_live) begin
          queue_word(held_char, held_kind_q, held_starts, 1'b1, clamp_line(token_start_line),
                     ST_END);
        end else begin
          queue_word(8'd0, KIND_SPECIAL, 1'b0, 1'b0, clamp_line(line_now), ST_END);
        end
      end
      clear_lexer();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Predict on accepted bytes, then compare accepted words in order
  always @(posedge clk) begin
    ttl_result_t want;
    if (rst) begin
      clear_lexer();
      words_due.delete();
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        lex_byte(in_ch.in_byte, in_ch.end_of_buffer);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (words_due.size() == 0) begin
          $error("unexpected word: out_byte %0d, status %0d", out_ch.out_byte, out_ch.status);
          fail_count++;
        end else begin
          want = words_due[0];
          words_due.delete(0);
          check_field("out_byte", want.out_byte, out_ch.out_byte);
          check_field("token_kind", want.token_kind, out_ch.token_kind);
          check_field("first_of_token", want.first_of_token, out_ch.first_of_token);
          check_field("last_of_token", want.last_of_token, out_ch.last_of_token);
          check_field("line_number", want.line_number, out_ch.line_number);
          check_field("status", want.status, out_ch.status);
        end
      end
    end
    words_pending = words_due.size();
  end

endmodule

FILE: bench/tb_text_token_lexer.sv
// Testbench top for the text token lexer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_text_token_lexer;
  import ttl_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_BYTES    = 500;

  localparam string LETTERS    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string ALNUM      = "abcdexyzABCDEXYZ_0123456789";
  localparam string NUM_START  = "0123456789.-";
  localparam string NUM_BODY   = "0123456789.e+-";
  localparam string SPECIALS   = "(){}[]<>=;,";
  localparam string BLANKS     = " \t\r\n";
  localparam string STR_CHARS  = " !#$%&'()*+,-./0123456789:;<=>?@AZaz_{}~\n\t";

  logic clk;
  logic rst;
  int   fail_count;
  int   words_pending;

  // Idling controls for the input and output sides
  logic quiet;
  logic long_hold;
  int   gap_pct;
  int   stall_pct;

  logic [7:0] text_bytes[$];

  ttl_in_if  in_ch ();
  ttl_out_if out_ch ();

  text_token_lexer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ttl_stream_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] rand_from(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic int rand_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 8;
      default: return 30;
    endcase
  endfunction

  // Content byte of a quoted string: anything but the closing quote
  function automatic logic [7:0] string_char();
    logic [7:0] c;
    c = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : rand_from(STR_CHARS);
    return (c == CH_QUOTE) ? 8'h27 : c;
  endfunction

  // Append one byte to the buffer under construction
  task automatic add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  // Offer one byte, with a random gap first, and hold it until accepted
  task automatic send_byte(input logic [7:0] c, input logic last_byte);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= c;
    in_ch.end_of_buffer <= last_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic close_buf);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], close_buf && i == s.len() - 1);
    end
  endtask

  // Build one buffer of well-formed tokens, sometimes broken by noise
  task automatic build_text(output int live);
    int pos;
    text_bytes.delete();
    for (int t = 0; t < $urandom_range(1, 8); t++) begin
      case ($urandom_range(0, 3))
        0: add_byte(rand_from(SPECIALS));
        1: begin
          add_byte(rand_from(LETTERS));
          repeat ($urandom_range(0, 6)) add_byte(rand_from(ALNUM));
        end
        2: begin
          add_byte(rand_from(NUM_START));
          repeat ($urandom_range(0, 6)) add_byte(rand_from(NUM_BODY));
        end
        default: begin
          add_byte(CH_QUOTE);
          repeat ($urandom_range(0, 6)) add_byte(string_char());
          add_byte(CH_QUOTE);
        end
      endcase
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 3)) add_byte(rand_from(BLANKS));
      end
    end
    live = text_bytes.size();
    pos  = $urandom_range(0, text_bytes.size());
    case ($urandom_range(0, 9))
      0: begin
        text_bytes.insert(pos, 8'($urandom_range(0, 255)));
        live = pos + 1;
      end
      1: begin
        text_bytes.insert(pos, CH_NUL);
        live = pos + 1;
      end
      2: begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4)) add_byte(string_char());
        live = text_bytes.size();
      end
      default: ;
    endcase
  endtask

  // Output side: random stall bursts, calm stretches, and one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    stall_pct    = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 49) == 0) begin
        stall_pct = rand_pct();
      end
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Cycle budget
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("text_token_lexer test failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int sent_live;
    int live;
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = '0;
    in_ch.end_of_buffer = 1'b0;
    quiet               = 1'b0;
    long_hold           = 1'b0;
    gap_pct             = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every token kind, every status, end mark in word, number, string, error and stopped modes
    gap_pct = 10;
    send_text("(x_9\n-1.5e+3", 1'b1);
    send_text("\"a\n\"", 1'b1);
    send_text("\"q", 1'b1);
    send_byte("z", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("#a", 1'b1);
    send_byte("b", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte("c", 1'b1);

    // Random buffers; hold the output off early so the input backs up
    sent_live = 0;
    long_hold = 1'b1;
    while (sent_live < RANDOM_BYTES) begin
      quiet   = (sent_live >= RANDOM_BYTES * 4 / 5);
      gap_pct = rand_pct();
      build_text(live);
      for (int i = 0; i < text_bytes.size(); i++) begin
        send_byte(text_bytes[i], i == text_bytes.size() - 1);
      end
      sent_live += live;
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow for stray words
    while (words_pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_token_lexer test passed");
    end else begin
      $display("text_token_lexer test failed");
    end
    $finish;
  end

endmodule

FILE: text_token_lexer.f
hw/rtl/ttl_pkg.sv
hw/rtl/ttl_if.sv
hw/rtl/ttl_front.sv
hw/rtl/ttl_queue.sv
hw/rtl/ttl_back.sv
hw/rtl/text_token_lexer.sv
bench/ttl_stream_checker.sv
bench/tb_text_token_lexer.sv
